@@ rtl/core/maf_pkg.sv @@
//------------------------------------------------------------------------------
// maf_pkg
// Shared widths, constants and state codes of the moving average filter.
//------------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

  // window and sample sizing
  localparam int MAX_WINDOW   = 512;
  localparam int SAMPLE_BITS  = 16;
  localparam int RESET_LENGTH = 10;

  // derived widths
  localparam int LEN_BITS  = $clog2(MAX_WINDOW + 1);
  localparam int POS_BITS  = $clog2(MAX_WINDOW);
  localparam int SUM_BITS  = SAMPLE_BITS + POS_BITS;
  localparam int FRAC_BITS = 8;
  localparam int DVD_BITS  = SUM_BITS + FRAC_BITS;
  localparam int CNT_BITS  = $clog2(DVD_BITS);

  // result range
  localparam int MEAN_BITS = 24;
  localparam logic [DVD_BITS:0] MEAN_POS_LIMIT = (DVD_BITS + 1)'(2 ** (MEAN_BITS - 1) - 1);
  localparam logic [DVD_BITS:0] MEAN_NEG_LIMIT = (DVD_BITS + 1)'(2 ** (MEAN_BITS - 1));

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/moving_average_filter.sv @@
//------------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over a ring of the last window_length samples.
//------------------------------------------------------------------------------
// Each transaction on the input carries one signed sample and yields one
// transaction on the output: the mean of the last window_length samples with
// 8 fraction bits, rounded toward minus infinity. Slots not yet written since
// the last clear count as zero. Writing window_length (clamped to 1..512)
// clears the window; write it only while no sample is in flight. A sample
// is taken only in idle; the sequencer then does the ring read and sum update,
// takes the sum's magnitude, runs the bit-serial restoring divider (one
// quotient bit per cycle), then rounds and saturates, waiting while the
// output is full and stalled. A finished mean waits in the output register
// while the next sample is taken. No clearing pass is needed after reset.
`default_nettype none

module moving_average_filter (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write_enable,
  input  wire logic [maf_pkg::LEN_BITS-1:0]            cfg_write_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [maf_pkg::SAMPLE_BITS-1:0]  sample,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [maf_pkg::MEAN_BITS-1:0]         window_mean
);

  import maf_pkg::*;

  state_t                      state, state_next;
  logic [LEN_BITS-1:0]         window_length, window_length_next;
  logic [POS_BITS-1:0]         write_position, write_position_next;
  logic                        wrapped, wrapped_next;
  logic signed [SUM_BITS-1:0]  running_sum, running_sum_next;
  logic signed [SAMPLE_BITS-1:0] sample_reg, sample_reg_next;
  logic                        negative, negative_next;
  logic [DVD_BITS-1:0]         dividend, dividend_next;
  logic [LEN_BITS-1:0]         remainder, remainder_next;
  logic [CNT_BITS-1:0]         bit_count, bit_count_next;
  logic                        out_valid_next;
  logic signed [MEAN_BITS-1:0] window_mean_next;

  logic                        ram_we;
  logic [SAMPLE_BITS-1:0]      ram_rdata;

  // combinational helpers
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic [LEN_BITS:0]             pos_inc;
  logic [SUM_BITS-1:0]           sum_mag;
  logic [LEN_BITS:0]             trial;
  logic                          trial_ok;
  logic [DVD_BITS:0]             quo_mag;
  logic [MEAN_BITS-1:0]          sat_mag;

  // ring of past samples
  maf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_position),
    .wdata (sample_reg),
    .raddr (write_position),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != ST_IDLE);

  // datapath helpers
  always_comb begin
    old_sample = wrapped ? signed'(ram_rdata) : '0;
    pos_inc    = {1'b0, LEN_BITS'(write_position)} + (LEN_BITS + 1)'(1);
    sum_mag    = running_sum[SUM_BITS-1] ? SUM_BITS'(-running_sum) : SUM_BITS'(running_sum);
    trial      = {remainder, dividend[DVD_BITS-1]};
    trial_ok   = (trial >= {1'b0, window_length});
    quo_mag    = {1'b0, dividend} + (DVD_BITS + 1)'(negative && (remainder != '0));
    if (negative) begin
      sat_mag = (quo_mag > MEAN_NEG_LIMIT) ? MEAN_BITS'(MEAN_NEG_LIMIT) : quo_mag[MEAN_BITS-1:0];
    end else begin
      sat_mag = (quo_mag > MEAN_POS_LIMIT) ? MEAN_BITS'(MEAN_POS_LIMIT) : quo_mag[MEAN_BITS-1:0];
    end
  end

  // next state and datapath control
  always_comb begin
    state_next          = state;
    window_length_next  = window_length;
    write_position_next = write_position;
    wrapped_next        = wrapped;
    running_sum_next    = running_sum;
    sample_reg_next     = sample_reg;
    negative_next       = negative;
    dividend_next       = dividend;
    remainder_next      = remainder;
    bit_count_next      = bit_count;
    out_valid_next      = out_valid && out_stall;
    window_mean_next    = window_mean;
    ram_we              = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          sample_reg_next = sample;
          state_next      = ST_UPDATE;
        end
      end
      // replace the oldest sample and advance the write position
      ST_UPDATE: begin
        ram_we           = 1'b1;
        running_sum_next = running_sum - SUM_BITS'(old_sample) + SUM_BITS'(sample_reg);
        if (pos_inc >= {1'b0, window_length}) begin
          write_position_next = '0;
          wrapped_next        = 1'b1;
        end else begin
          write_position_next = pos_inc[POS_BITS-1:0];
        end
        state_next = ST_PREP;
      end
      // load the divider with the scaled magnitude
      ST_PREP: begin
        negative_next  = running_sum[SUM_BITS-1];
        dividend_next  = {sum_mag, FRAC_BITS'(0)};
        remainder_next = '0;
        bit_count_next = CNT_BITS'(DVD_BITS - 1);
        state_next     = ST_DIVIDE;
      end
      // one restoring division step per cycle
      ST_DIVIDE: begin
        remainder_next = trial_ok ? LEN_BITS'(trial - {1'b0, window_length})
                                  : trial[LEN_BITS-1:0];
        dividend_next  = {dividend[DVD_BITS-2:0], trial_ok};
        bit_count_next = bit_count - CNT_BITS'(1);
        if (bit_count == '0) begin
          state_next = ST_FINISH;
        end
      end
      // floor, saturate and hand over to the output register
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_valid_next   = 1'b1;
          window_mean_next = negative ? signed'(-sat_mag) : signed'(sat_mag);
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // length write clears the window
    if (cfg_write_enable) begin
      if (cfg_write_data == '0) begin
        window_length_next = LEN_BITS'(1);
      end else if (cfg_write_data > LEN_BITS'(MAX_WINDOW)) begin
        window_length_next = LEN_BITS'(MAX_WINDOW);
      end else begin
        window_length_next = cfg_write_data;
      end
      write_position_next = '0;
      wrapped_next        = 1'b0;
      running_sum_next    = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      window_length  <= LEN_BITS'(RESET_LENGTH);
      write_position <= '0;
      wrapped        <= 1'b0;
      running_sum    <= '0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      window_length  <= window_length_next;
      write_position <= write_position_next;
      wrapped        <= wrapped_next;
      running_sum    <= running_sum_next;
      out_valid      <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sample_reg  <= sample_reg_next;
    negative    <= negative_next;
    dividend    <= dividend_next;
    remainder   <= remainder_next;
    bit_count   <= bit_count_next;
    window_mean <= window_mean_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/maf_ram.sv @@
//------------------------------------------------------------------------------
// maf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
//------------------------------------------------------------------------------
`default_nettype none

module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ tb/sv/moving_average_filter_test.sv @@
//------------------------------------------------------------------------------
// moving_average_filter_test
// Self-checking testbench for the boxcar moving average filter.
//------------------------------------------------------------------------------
// Samples are sent through the valid/stall input channel with random gaps.
// A software copy of the ring, write position and running sum predicts each
// window mean, and every output transaction is checked against the oldest
// prediction. The window length is written only while no sample is in flight,
// and is swept through its clamped extremes and random values. The output
// side applies random back-pressure.
//------------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import maf_pkg::*;

  localparam int  RANDOM_ITEMS  = 1700;
  localparam int  MAX_IDLE      = 11;
  localparam int  SETTLE_CYCLES = 40;
  localparam int  REPORT_LIMIT  = 10;
  localparam real RUN_LIMIT_NS  = 4_000_000.0;

  // clock, reset and block ports
  logic                          clk;
  logic                          rst;
  logic                          cfg_write_enable;
  logic [LEN_BITS-1:0]           cfg_write_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [MEAN_BITS-1:0]   window_mean;

  // predictor state of the window
  logic signed [SAMPLE_BITS-1:0] ring_copy [MAX_WINDOW];
  int                            write_slot;
  longint                        window_sum;
  int                            window_len;

  // expected means, oldest first
  logic signed [MEAN_BITS-1:0]   pending_means [$];

  int failure_count;
  int in_gap_max;
  int out_stall_max;
  int stall_left;

  moving_average_filter uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .window_mean      (window_mean)
  );

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // clear the predicted window
  function automatic void clear_window_copy();
    foreach (ring_copy[i]) ring_copy[i] = '0;
    write_slot = 0;
    window_sum = 0;
  endfunction

  // advance the predicted window by one sample and return its mean
  function automatic logic signed [MEAN_BITS-1:0] next_window_mean(
      input logic signed [SAMPLE_BITS-1:0] value);
    longint scaled;
    longint quotient;
    longint mean_hi;
    longint mean_lo;
    mean_hi = (64'sd1 <<< (MEAN_BITS - 1)) - 1;
    mean_lo = -(64'sd1 <<< (MEAN_BITS - 1));
    window_sum = window_sum - ring_copy[write_slot] + value;
    ring_copy[write_slot] = value;
    write_slot = (write_slot + 1 >= window_len) ? 0 : write_slot + 1;
    // floor of sum * 2^frac / length
    scaled = window_sum * (64'sd1 <<< FRAC_BITS);
    quotient = scaled / window_len;
    if (scaled < 0 && (scaled % window_len) != 0) quotient = quotient - 1;
    if (quotient > mean_hi) quotient = mean_hi;
    if (quotient < mean_lo) quotient = mean_lo;
    return quotient[MEAN_BITS-1:0];
  endfunction

  // send one sample transaction after a random gap
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
    pending_means.push_back(next_window_mean(value));
  endtask

  // stop sending and wait until every expected mean has arrived
  task automatic wait_for_means();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_means.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write the window length while the block is idle
  task automatic set_window_length(input logic [LEN_BITS-1:0] value);
    wait_for_means();
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    if (value < 1) window_len = 1;
    else if (value > MAX_WINDOW) window_len = MAX_WINDOW;
    else window_len = value;
    clear_window_copy();
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // random sample, biased toward extremes; bias 1 negative, 2 positive
  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input int bias);
    int v;
    case ($urandom_range(0, 7))
      0:       v = (bias == 1) ? -32768 : 32767;
      1:       v = (bias == 2) ? 32767 : -32768;
      2:       v = int'($urandom_range(0, 8)) - 4;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (bias == 1 && v > 0) v = -v;
    if (bias == 2 && v < 0) v = -(v + 1);
    return v[SAMPLE_BITS-1:0];
  endfunction

  // output back-pressure, redrawn after each output transaction
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each output transaction with the oldest expected mean
  always @(posedge clk) begin
    logic signed [MEAN_BITS-1:0] expected_mean;
    if (!rst && out_valid && !out_stall) begin
      stall_left <= $urandom_range(0, out_stall_max);
      if (pending_means.size() == 0) begin
        failure_count = failure_count + 1;
        if (failure_count <= REPORT_LIMIT)
          $display("unexpected window_mean %0d", window_mean);
      end else begin
        expected_mean = pending_means.pop_front();
        if (window_mean !== expected_mean) begin
          failure_count = failure_count + 1;
          if (failure_count <= REPORT_LIMIT)
            $display("window_mean mismatch: expected %0d, actual %0d",
                     expected_mean, window_mean);
        end
      end
    end
  end

  // reset length of ten, wrap of the ring, sample extremes
  task automatic test_default_window();
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(-16'sh8000);
    push_sample(-16'sh8000);
    push_sample(-16'sh8000);
    push_sample(16'sh0000);
    push_sample(-16'sh0001);
    push_sample(16'sh0001);
    push_sample(16'sh3039);
    push_sample(-16'sh0001);
    push_sample(-16'sh8000);
    wait_for_means();
  endtask

  // length zero, lengths beyond the maximum, smallest lengths
  task automatic test_length_extremes();
    set_window_length(10'd0);
    push_sample(-16'sh8000);
    push_sample(16'sh7fff);
    push_sample(-16'sh0001);
    set_window_length(10'h3ff);
    push_sample(16'sh7fff);
    push_sample(-16'sh8000);
    push_sample(-16'sh0001);
    set_window_length(10'(MAX_WINDOW + 1));
    push_sample(-16'sh0001);
    set_window_length(10'd2);
    push_sample(16'sh7fff);
    push_sample(16'sh7fff);
    push_sample(-16'sh8000);
    wait_for_means();
  endtask

  // rewriting the same length clears the window
  task automatic test_length_write_clears();
    set_window_length(10'd2);
    push_sample(-16'sh0001);
    push_sample(16'sh0005);
    set_window_length(10'd2);
    push_sample(-16'sh0001);
    wait_for_means();
  endtask

  // random lengths and samples, one full wrap at the largest window
  task automatic test_random_windows();
    int sent;
    int phase;
    int cfg_value;
    int count;
    int bias;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        cfg_value = $urandom_range(MAX_WINDOW, (1 << LEN_BITS) - 1);
      end else begin
        case ($urandom_range(0, 7))
          0:       cfg_value = 0;
          1:       cfg_value = 1;
          2:       cfg_value = MAX_WINDOW;
          3, 4, 5: cfg_value = $urandom_range(2, 24);
          default: cfg_value = $urandom_range(0, (1 << LEN_BITS) - 1);
        endcase
      end
      // idle stretches per phase, sometimes none at all
      in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      bias          = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      set_window_length(cfg_value[LEN_BITS-1:0]);
      if (phase == 0) count = window_len + $urandom_range(20, 60);
      else if (window_len <= 64) count = 2 * window_len + $urandom_range(1, 20);
      else count = $urandom_range(20, 80);
      repeat (count) begin
        push_sample(draw_sample(bias));
        sent = sent + 1;
        if ($urandom_range(0, 99) == 0) wait_for_means();
      end
      phase = phase + 1;
    end
    wait_for_means();
  endtask

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // main sequence
  initial begin
    rst              = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_write_data   = '0;
    in_valid         = 1'b0;
    sample           = '0;
    out_stall        = 1'b0;
    stall_left       = 0;
    failure_count    = 0;
    in_gap_max       = MAX_IDLE;
    out_stall_max    = MAX_IDLE;
    window_len       = RESET_LENGTH;
    clear_window_copy();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_window();
    test_length_extremes();
    test_length_write_clears();
    test_random_windows();

    // let any stray output show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_means.size() > 0) failure_count = failure_count + 1;
    if (failure_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
